@@ rtl/clipped_bresenham_line_stepper_unit_defines.svh @@
`ifndef CLIPPED_BRESENHAM_LINE_STEPPER_UNIT_DEFINES_SVH
`define CLIPPED_BRESENHAM_LINE_STEPPER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define CLBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define CLBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/clbs_pkg.sv @@
`timescale 1ns / 1ps

package clbs_pkg;

    localparam int COORD_BITS    = 16;
    localparam int ADDR_BITS     = 32;
    localparam int STRIDE_BITS   = 16;
    localparam int COLOR_BITS    = 8;
    localparam int DELTA_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS      = COORD_BITS + 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // command codes
    localparam logic CMD_START = 1'b0;

    // register reset values
    localparam logic [ADDR_BITS-1:0]   RST_FRAME_BASE  = '0;
    localparam logic [STRIDE_BITS-1:0] RST_ROW_STRIDE  = STRIDE_BITS'(640);
    localparam logic [COORD_BITS-1:0]  RST_CLIP_LEFT   = '0;
    localparam logic [COORD_BITS-1:0]  RST_CLIP_TOP    = '0;
    localparam logic [COORD_BITS-1:0]  RST_CLIP_RIGHT  = COORD_BITS'(639);
    localparam logic [COORD_BITS-1:0]  RST_CLIP_BOTTOM = COORD_BITS'(479);
    localparam logic [COLOR_BITS-1:0]  RST_DRAW_COLOR  = '0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_BASE,
        CFG_ROW_STRIDE,
        CFG_CLIP_LEFT,
        CFG_CLIP_TOP,
        CFG_CLIP_RIGHT,
        CFG_CLIP_BOTTOM,
        CFG_DRAW_COLOR
    } t_cfg_index;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   command;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_item;

    typedef struct packed {
        logic                  pixel_valid;
        t_coord                pixel_x;
        t_coord                pixel_y;
        logic [ADDR_BITS-1:0]  pixel_address;
        logic                  write_enable;
        logic [COLOR_BITS-1:0] pixel_value;
        logic                  last;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   frame_base;
        logic [STRIDE_BITS-1:0] row_stride;
        t_coord                 clip_left;
        t_coord                 clip_top;
        t_coord                 clip_right;
        t_coord                 clip_bottom;
        logic [COLOR_BITS-1:0]  draw_color;
    } t_cfg;

    // endpoints after the swap, with absolute deltas
    typedef struct packed {
        logic                  cmd;
        t_coord                x1;
        t_coord                y1;
        logic [DELTA_BITS-1:0] dx;
        logic [DELTA_BITS-1:0] dy;
        logic                  y_up;
    } t_diff;

    // full line setup handed to the stepper
    typedef struct packed {
        logic                  cmd;
        t_coord                x1;
        t_coord                y1;
        logic                  x_major;
        logic                  y_up;
        logic [DELTA_BITS-1:0] major;
        logic [DELTA_BITS-1:0] minor;
        logic [DELTA_BITS-1:0] pixels;
        logic [ADDR_BITS-1:0]  row_addr;
        logic [ADDR_BITS-1:0]  col_addr;
    } t_setup;

endpackage

@@ rtl/clipped_bresenham_line_stepper_unit.sv @@
`timescale 1ns / 1ps
// Clipped Bresenham line stepper for an 8-bit framebuffer.
// Input channel (i_in_valid / o_in_stall): a start beat loads both endpoints
// and yields the first pixel; each step beat yields the next pixel. Every
// input beat gives exactly one output beat (o_out_valid / i_out_stall); a step
// with no line active gives a beat with all fields zero.
// Config channel (i_cfg_valid / o_cfg_ready): always ready, one register per
// beat; the user must write only while the block is idle; not enforced.
// Stages from input accept to output beat: endpoint swap and deltas, row
// product and column address, stepper with output register.
// Throughput: one beat per cycle when not stalled; the error/address update
// loops on the stepper's registers, so steps may follow a start back to back.
// Stall: the output register holds its beat while i_out_stall is high and the
// stall ripples back through the two setup stages to o_in_stall, so up to
// three beats wait inside.
// Reset: registers return to their defaults (stride 640, clip 0..639 by
// 0..479), no line is active and the pipeline is empty.

module clipped_bresenham_line_stepper_unit import clbs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   setup_valid;
    logic   setup_ready;
    t_setup setup;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base  <= RST_FRAME_BASE;
            r_cfg.row_stride  <= RST_ROW_STRIDE;
            r_cfg.clip_left   <= RST_CLIP_LEFT;
            r_cfg.clip_top    <= RST_CLIP_TOP;
            r_cfg.clip_right  <= RST_CLIP_RIGHT;
            r_cfg.clip_bottom <= RST_CLIP_BOTTOM;
            r_cfg.draw_color  <= RST_DRAW_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_BASE:  r_cfg.frame_base  <= i_cfg_data[ADDR_BITS-1:0];
                CFG_ROW_STRIDE:  r_cfg.row_stride  <= i_cfg_data[STRIDE_BITS-1:0];
                CFG_CLIP_LEFT:   r_cfg.clip_left   <= i_cfg_data[COORD_BITS-1:0];
                CFG_CLIP_TOP:    r_cfg.clip_top    <= i_cfg_data[COORD_BITS-1:0];
                CFG_CLIP_RIGHT:  r_cfg.clip_right  <= i_cfg_data[COORD_BITS-1:0];
                CFG_CLIP_BOTTOM: r_cfg.clip_bottom <= i_cfg_data[COORD_BITS-1:0];
                CFG_DRAW_COLOR:  r_cfg.draw_color  <= i_cfg_data[COLOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    clbs_setup u_setup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_cfg         (r_cfg),
        .o_setup_valid (setup_valid),
        .i_setup_ready (setup_ready),
        .o_setup       (setup)
    );

    clbs_stepper u_stepper (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_setup_valid (setup_valid),
        .o_setup_ready (setup_ready),
        .i_setup       (setup),
        .i_cfg         (r_cfg),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

@@ rtl/clbs_setup.sv @@
`timescale 1ns / 1ps

module clbs_setup import clbs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  t_cfg     i_cfg,
    output logic     o_setup_valid,
    input  logic     i_setup_ready,
    output t_setup   o_setup
);

    logic   r_s1_valid;
    logic   r_s2_valid;
    t_diff  r_s1;
    t_diff  n_s1;
    t_setup r_s2;
    t_setup n_s2;
    logic   s1_ready;
    logic   s2_ready;

    logic                                   swap;
    t_coord                                 sx1;
    t_coord                                 sy1;
    t_coord                                 sx2;
    t_coord                                 sy2;
    logic signed [DELTA_BITS-1:0]           dy_s;
    logic signed [COORD_BITS+STRIDE_BITS:0] row_prod;

    // stage 1: order endpoints so x rises, take deltas
    always_comb begin
        swap = $signed(i_in_data.start_x) > $signed(i_in_data.end_x);
        sx1  = swap ? i_in_data.end_x   : i_in_data.start_x;
        sy1  = swap ? i_in_data.end_y   : i_in_data.start_y;
        sx2  = swap ? i_in_data.start_x : i_in_data.end_x;
        sy2  = swap ? i_in_data.start_y : i_in_data.end_y;
        dy_s = $signed({sy2[COORD_BITS-1], sy2}) - $signed({sy1[COORD_BITS-1], sy1});

        n_s1.cmd  = i_in_data.command;
        n_s1.x1   = sx1;
        n_s1.y1   = sy1;
        n_s1.dx   = {sx2[COORD_BITS-1], sx2} - {sx1[COORD_BITS-1], sx1};
        n_s1.y_up = dy_s[DELTA_BITS-1];
        n_s1.dy   = dy_s[DELTA_BITS-1] ? (~dy_s + 1'b1) : dy_s;
    end

    // stage 2: pick major axis, row offset product, column address
    always_comb begin
        row_prod = $signed(r_s1.y1) * $signed({1'b0, i_cfg.row_stride});

        n_s2.cmd      = r_s1.cmd;
        n_s2.x1       = r_s1.x1;
        n_s2.y1       = r_s1.y1;
        n_s2.y_up     = r_s1.y_up;
        n_s2.x_major  = r_s1.dx > r_s1.dy;
        n_s2.major    = n_s2.x_major ? r_s1.dx : r_s1.dy;
        n_s2.minor    = n_s2.x_major ? r_s1.dy : r_s1.dx;
        n_s2.pixels   = n_s2.major + 1'b1;
        n_s2.row_addr = ADDR_BITS'(row_prod);
        n_s2.col_addr = i_cfg.frame_base + ADDR_BITS'(r_s1.x1);
    end

    // pipeline flow control
    assign s2_ready      = !r_s2_valid || i_setup_ready;
    assign s1_ready      = !r_s1_valid || s2_ready;
    assign o_in_stall    = !s1_ready;
    assign o_setup_valid = r_s2_valid;
    assign o_setup       = r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1 <= n_s1;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

@@ rtl/clbs_stepper.sv @@
`timescale 1ns / 1ps
`include "clipped_bresenham_line_stepper_unit_defines.svh"

module clbs_stepper import clbs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_setup_valid,
    output logic      o_setup_ready,
    input  t_setup    i_setup,
    input  t_cfg      i_cfg,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // line state
    logic                  r_active;
    logic                  r_xm;
    logic                  r_yup;
    t_coord                r_x;
    t_coord                r_y;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [ERR_BITS-1:0]   r_err;
    logic [DELTA_BITS-1:0] r_major;
    logic [DELTA_BITS-1:0] r_minor;
    logic [DELTA_BITS-1:0] r_pl;

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // working copy: fresh setup on start, stored state on step
    logic                  is_start;
    logic                  fire;
    logic                  w_active;
    logic                  w_xm;
    logic                  w_yup;
    t_coord                w_x;
    t_coord                w_y;
    logic [ADDR_BITS-1:0]  w_addr;
    logic [ERR_BITS-1:0]   w_err;
    logic [DELTA_BITS-1:0] w_major;
    logic [DELTA_BITS-1:0] w_minor;
    logic [DELTA_BITS-1:0] w_pl;

    logic [ERR_BITS-1:0]          sum;
    logic                         minor_step;
    logic                         x_moves;
    logic                         y_moves;
    logic signed [DELTA_BITS-1:0] x_plus;
    logic signed [DELTA_BITS-1:0] right_ext;
    logic                         in_clip;
    logic [ADDR_BITS-1:0]         stride_ext;
    logic [ADDR_BITS-1:0]         row_step;
    t_coord                       y_step;

    logic                  n_last;
    t_coord                n_x;
    t_coord                n_y;
    logic [ADDR_BITS-1:0]  n_addr;
    logic [ERR_BITS-1:0]   n_err;
    logic [DELTA_BITS-1:0] n_pl;

    assign is_start      = i_setup.cmd == CMD_START;
    assign o_setup_ready = !r_out_valid || !i_out_stall;
    assign fire          = i_setup_valid && o_setup_ready;

    // select working state
    always_comb begin
        if (is_start) begin
            w_active = 1'b1;
            w_xm     = i_setup.x_major;
            w_yup    = i_setup.y_up;
            w_x      = i_setup.x1;
            w_y      = i_setup.y1;
            w_addr   = i_setup.row_addr + i_setup.col_addr;
            w_err    = ERR_BITS'(i_setup.major >> 1);
            w_major  = i_setup.major;
            w_minor  = i_setup.minor;
            w_pl     = i_setup.pixels;
        end else begin
            w_active = r_active;
            w_xm     = r_xm;
            w_yup    = r_yup;
            w_x      = r_x;
            w_y      = r_y;
            w_addr   = r_addr;
            w_err    = r_err;
            w_major  = r_major;
            w_minor  = r_minor;
            w_pl     = r_pl;
        end
    end

    // pixel emit and Bresenham advance
    always_comb begin
        sum        = w_err + {1'b0, w_minor};
        minor_step = sum >= {1'b0, w_major};
        x_moves    = w_xm || minor_step;
        y_moves    = !w_xm || minor_step;

        // right edge test without coordinate wrap
        x_plus    = {w_x[COORD_BITS-1], w_x} + DELTA_BITS'(1);
        right_ext = {i_cfg.clip_right[COORD_BITS-1], i_cfg.clip_right};
        n_last    = (w_pl <= DELTA_BITS'(1)) || (x_moves && (x_plus > right_ext));

        in_clip = (w_x >= i_cfg.clip_left) && (w_x <= i_cfg.clip_right) &&
                  (w_y >= i_cfg.clip_top) && (w_y <= i_cfg.clip_bottom);

        stride_ext = ADDR_BITS'(i_cfg.row_stride);
        row_step   = w_yup ? (~stride_ext + 1'b1) : stride_ext;
        y_step     = w_yup ? (w_y - 1'b1) : (w_y + 1'b1);

        n_err  = minor_step ? (sum - {1'b0, w_major}) : sum;
        n_x    = x_moves ? (w_x + 1'b1) : w_x;
        n_y    = y_moves ? y_step : w_y;
        n_addr = w_addr + (x_moves ? ADDR_BITS'(1) : '0) + (y_moves ? row_step : '0);
        n_pl   = (w_pl != '0) ? (w_pl - 1'b1) : w_pl;

        if (w_active) begin
            n_out.pixel_valid   = 1'b1;
            n_out.pixel_x       = w_x;
            n_out.pixel_y       = w_y;
            n_out.pixel_address = w_addr;
            n_out.write_enable  = in_clip;
            n_out.pixel_value   = i_cfg.draw_color;
            n_out.last          = n_last;
        end else begin
            n_out = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire && w_active) begin
                r_active <= !n_last;
            end
            if (o_setup_ready) begin
                r_out_valid <= i_setup_valid;
            end
        end
    end

    // line state and result beat
    always_ff @(posedge i_clk) begin
        if (fire && w_active) begin
            r_xm    <= w_xm;
            r_yup   <= w_yup;
            r_x     <= n_x;
            r_y     <= n_y;
            r_addr  <= n_addr;
            r_err   <= n_err;
            r_major <= w_major;
            r_minor <= w_minor;
            r_pl    <= n_pl;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CLBS_ASSERT_IMP(a_active_has_pixels, r_active, r_pl != '0, "active line with no pixels left")
    `CLBS_ASSERT_IMP(a_err_below_major, r_active, r_err < {1'b0, r_major}, "error term out of range")
    `CLBS_ASSERT_NEXT(a_last_ends_line, fire && w_active && n_last, !r_active, "line alive after last")
    `CLBS_ASSERT_NEXT(a_start_opens_line, fire && is_start && !n_last, r_active && r_out.pixel_valid, "start did not open a line")
    `CLBS_ASSERT_IMP(a_idle_beat_zero, r_out_valid && !r_out.pixel_valid, r_out.pixel_address == '0 && !r_out.write_enable && !r_out.last, "idle beat not cleared")

endmodule

@@ tb/clipped_bresenham_line_stepper_unit_test.sv @@
`timescale 1ns / 1ps

module clipped_bresenham_line_stepper_unit_test;
    import clbs_pkg::*;

    localparam logic      CMD_STEP     = 1'b1;
    localparam int        DIR_ROWS     = 24;
    localparam int        PHASES       = 6;
    localparam int        PHASE_BEATS  = 100;
    localparam int        HOLD_CYCLES  = 80;
    localparam int        HOLD_AT_BEAT = 250;
    localparam t_out_item NO_PIXEL     = '0;

    // one row of the directed part; want is used only when typed is set
    typedef struct packed {
        logic      typed;
        t_in_item  beat;
        t_out_item want;
    } t_dir_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     in_valid;
    logic                     in_stall;
    t_in_item                 in_beat;
    logic                     out_valid;
    logic                     out_stall;
    t_out_item                out_beat;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // predictor copy of the registers
    logic [ADDR_BITS-1:0]   cfg_frame_base;
    logic [STRIDE_BITS-1:0] cfg_stride;
    t_coord                 cfg_left;
    t_coord                 cfg_top;
    t_coord                 cfg_right;
    t_coord                 cfg_bottom;
    logic [COLOR_BITS-1:0]  cfg_color;

    // predictor copy of the line state
    logic                 line_active;
    logic                 x_major;
    logic                 y_up;
    t_coord               cur_x;
    t_coord               cur_y;
    logic [ADDR_BITS-1:0] cur_addr;
    int                   err_acc;
    int                   major_len;
    int                   minor_len;
    int                   pixels_left;

    t_out_item pixel_queue[$];
    t_dir_row  dir_rows[DIR_ROWS];
    int        fail_count = 0;
    int        beats_sent = 0;
    int        calm_left  = 0;
    logic      hold_done  = 1'b0;

    clipped_bresenham_line_stepper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // plot the current pixel, then advance one Bresenham step
    function automatic t_out_item trace_pixel();
        t_out_item            px;
        int                   sum;
        logic                 minor_step;
        logic                 x_moves;
        logic                 line_done;
        logic [ADDR_BITS-1:0] row_step;
        sum        = err_acc + minor_len;
        minor_step = (sum >= major_len);
        x_moves    = x_major || minor_step;
        // ends by count, or when x would pass the clip's right edge
        line_done  = (pixels_left <= 1) ||
                     (x_moves && (int'(cur_x) + 1 > int'(cfg_right)));
        row_step   = y_up ? ADDR_BITS'(0) - ADDR_BITS'(cfg_stride) : ADDR_BITS'(cfg_stride);

        px.pixel_valid   = 1'b1;
        px.pixel_x       = cur_x;
        px.pixel_y       = cur_y;
        px.pixel_address = cur_addr;
        px.write_enable  = (cur_x >= cfg_left) && (cur_x <= cfg_right) &&
                           (cur_y >= cfg_top) && (cur_y <= cfg_bottom);
        px.pixel_value   = cfg_color;
        px.last          = line_done;

        if (minor_step)
            sum = sum - major_len;
        err_acc = sum;
        if (x_moves) begin
            cur_x    = cur_x + 16'sd1;
            cur_addr = cur_addr + ADDR_BITS'(1);
        end
        if (!x_major || minor_step) begin
            cur_y    = y_up ? cur_y - 16'sd1 : cur_y + 16'sd1;
            cur_addr = cur_addr + row_step;
        end
        if (pixels_left > 0)
            pixels_left = pixels_left - 1;
        if (line_done)
            line_active = 1'b0;
        return px;
    endfunction

    // expected pixel beat for one accepted command beat
    function automatic t_out_item line_response(input t_in_item beat);
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
        t_coord tmp;
        int     dx;
        int     dy;
        if (beat.command == CMD_START) begin
            x1 = beat.start_x;
            y1 = beat.start_y;
            x2 = beat.end_x;
            y2 = beat.end_y;
            // swap so that x never decreases
            if (x1 > x2) begin
                tmp = x1; x1 = x2; x2 = tmp;
                tmp = y1; y1 = y2; y2 = tmp;
            end
            dx          = int'(x2) - int'(x1);
            dy          = int'(y2) - int'(y1);
            y_up        = (dy < 0);
            if (dy < 0)
                dy = -dy;
            x_major     = (dx > dy);
            major_len   = x_major ? dx : dy;
            minor_len   = x_major ? dy : dx;
            err_acc     = major_len / 2;
            pixels_left = major_len + 1;
            cur_x       = x1;
            cur_y       = y1;
            cur_addr    = cfg_frame_base + ADDR_BITS'(int'(y1) * int'(cfg_stride)) +
                          ADDR_BITS'(int'(x1));
            line_active = 1'b1;
            return trace_pixel();
        end
        if (line_active)
            return trace_pixel();
        return NO_PIXEL;
    endfunction

    function automatic t_coord pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return COORD_BITS'(int'($urandom_range(0, 200)) - 60);
        if (r <= 7)
            return COORD_BITS'(int'(cfg_right) + int'($urandom_range(0, 16)) - 8);
        if (r == 8)
            return COORD_BITS'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh8001;
            default: return 16'sh7ffe;
        endcase
    endfunction

    // step beat; the endpoint fields carry junk that the block must ignore
    function automatic t_in_item step_beat();
        t_in_item beat;
        beat.command = CMD_STEP;
        beat.start_x = COORD_BITS'($urandom);
        beat.start_y = COORD_BITS'($urandom);
        beat.end_x   = COORD_BITS'($urandom);
        beat.end_y   = COORD_BITS'($urandom);
        return beat;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // offer one command beat, record its expected pixel, then maybe idle a while
    task automatic offer_beat(input t_in_item beat, input logic typed, input t_out_item want);
        t_out_item predicted;
        int        gap;
        int        r;
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        predicted = line_response(beat);
        pixel_queue.push_back(typed ? want : predicted);
        beats_sent++;
        @(negedge i_clk);
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            gap = 0;
        end else if (r < 5) begin
            calm_left = $urandom_range(10, 40);
            gap       = 0;
        end else if (r < 55) begin
            gap = 0;
        end else if (r < 85) begin
            gap = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // stop offering and let every expected pixel drain
    task automatic settle();
        in_valid <= 1'b0;
        while (pixel_queue.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_FRAME_BASE:  cfg_frame_base = value[ADDR_BITS-1:0];
            CFG_ROW_STRIDE:  cfg_stride     = value[STRIDE_BITS-1:0];
            CFG_CLIP_LEFT:   cfg_left       = value[COORD_BITS-1:0];
            CFG_CLIP_TOP:    cfg_top        = value[COORD_BITS-1:0];
            CFG_CLIP_RIGHT:  cfg_right      = value[COORD_BITS-1:0];
            CFG_CLIP_BOTTOM: cfg_bottom     = value[COORD_BITS-1:0];
            CFG_DRAW_COLOR:  cfg_color      = value[COLOR_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_setting(input logic [31:0] base, input logic [15:0] stride,
                                input int left, input int top, input int right,
                                input int bottom, input logic [7:0] color);
        write_reg(CFG_FRAME_BASE, base);
        write_reg(CFG_ROW_STRIDE, 32'(stride));
        write_reg(CFG_CLIP_LEFT, 32'(left));
        write_reg(CFG_CLIP_TOP, 32'(top));
        write_reg(CFG_CLIP_RIGHT, 32'(right));
        write_reg(CFG_CLIP_BOTTOM, 32'(bottom));
        write_reg(CFG_DRAW_COLOR, 32'(color));
        cfg_valid <= 1'b0;
    endtask

    // check each pixel beat against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pixel_queue.size() == 0) begin
                $display("%0t ns: pixel beat with nothing expected, got %h", $time, out_beat);
                fail_count++;
            end else begin
                want = pixel_queue.pop_front();
                compare_field("pixel_valid", 32'(want.pixel_valid), 32'(out_beat.pixel_valid));
                compare_field("pixel_x", 32'(want.pixel_x), 32'(out_beat.pixel_x));
                compare_field("pixel_y", 32'(want.pixel_y), 32'(out_beat.pixel_y));
                compare_field("pixel_address", want.pixel_address, out_beat.pixel_address);
                compare_field("write_enable", 32'(want.write_enable),
                              32'(out_beat.write_enable));
                compare_field("pixel_value", 32'(want.pixel_value), 32'(out_beat.pixel_value));
                compare_field("last", 32'(want.last), 32'(out_beat.last));
            end
        end
    end

    // receiver: random stall runs, plus one long hold-off to back the block up
    initial begin
        int   run_left;
        logic stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                run_left = 0;
            end
            if (run_left == 0) begin
                stall_now = ($urandom_range(0, 3) == 0);
                if (stall_now)
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                           : $urandom_range(1, 3);
                else
                    run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                           : $urandom_range(1, 8);
            end
            out_stall <= stall_now;
            run_left--;
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_in_item beat;
        t_coord   x1;
        t_coord   y1;
        int       steps;
        int       mode;
        int       phase_end;
        int       clip_l;
        int       clip_t;

        in_valid  = 1'b0;
        in_beat   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        i_rst_n   = 1'b0;

        cfg_frame_base = RST_FRAME_BASE;
        cfg_stride     = RST_ROW_STRIDE;
        cfg_left       = RST_CLIP_LEFT;
        cfg_top        = RST_CLIP_TOP;
        cfg_right      = RST_CLIP_RIGHT;
        cfg_bottom     = RST_CLIP_BOTTOM;
        cfg_color      = RST_DRAW_COLOR;
        line_active    = 1'b0;
        x_major        = 1'b0;
        y_up           = 1'b0;
        cur_x          = '0;
        cur_y          = '0;
        cur_addr       = '0;
        err_acc        = 0;
        major_len      = 0;
        minor_len      = 0;
        pixels_left    = 0;

        // directed part, run with the reset register values
        dir_rows = '{
            // step with no line: all-zero beat
            '{1'b1, '{CMD_STEP, 16'shffff, 16'shffff, 16'shffff, 16'shffff}, NO_PIXEL},
            // single-pixel line at the origin
            '{1'b1, '{CMD_START, 16'sh0, 16'sh0, 16'sh0, 16'sh0},
              '{1'b1, 16'sh0, 16'sh0, 32'h0, 1'b1, 8'h00, 1'b1}},
            '{1'b1, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            // x-major, y falling
            '{1'b0, '{CMD_START, 16'sd10, 16'sd5, 16'sd20, 16'sd8}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh1234, 16'sh5678, 16'sh9abc, 16'shdef0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            // swapped endpoints, y-major rising; drops the active line
            '{1'b0, '{CMD_START, 16'sd30, 16'sd40, 16'sd25, 16'sd60}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            // coordinate extremes as single pixels, outside the clip
            '{1'b1, '{CMD_START, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
              '{1'b1, 16'sh8000, 16'sh8000, 32'hfebf8000, 1'b0, 8'h00, 1'b1}},
            '{1'b1, '{CMD_START, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
              '{1'b1, 16'sh7fff, 16'sh7fff, 32'h01407d7f, 1'b0, 8'h00, 1'b1}},
            // x-major line cut short at the clip's right edge
            '{1'b0, '{CMD_START, 16'sd636, 16'sd10, 16'sd700, 16'sd12}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            // full-range diagonal
            '{1'b0, '{CMD_START, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            // y-major line whose x step crosses the right edge
            '{1'b0, '{CMD_START, 16'sd639, 16'sd0, 16'sd641, 16'sd10}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL},
            '{1'b0, '{CMD_STEP, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, NO_PIXEL}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        // random part, one register setting per phase
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            clip_l = int'($urandom_range(0, 100)) - 50;
            clip_t = int'($urandom_range(0, 100)) - 50;
            case (phase)
                0: load_setting(32'hffff_ffff, 16'hffff, -32768, -32768, 32767, 32767, 8'hff);
                1: load_setting(32'h0, 16'd1, 100, 0, 50, 479, 8'h00);
                3: load_setting($urandom, 16'd640, 0, 32767, 639, -32768, 8'($urandom));
                5: load_setting(32'h1000_0000, 16'd320, 0, 0, 319, 239, 8'($urandom));
                default: load_setting($urandom, 16'($urandom_range(1, 65535)), clip_l, clip_t,
                                      clip_l + int'($urandom_range(0, 150)),
                                      clip_t + int'($urandom_range(0, 150)), 8'($urandom));
            endcase

            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                mode = $urandom_range(0, 9);
                beat = step_beat();
                if (mode == 9) begin
                    // stray step, often with no line active
                    offer_beat(beat, 1'b0, NO_PIXEL);
                end else begin
                    x1 = pick_coord();
                    y1 = pick_coord();
                    beat.command = CMD_START;
                    beat.start_x = x1;
                    beat.start_y = y1;
                    if (mode < 7) begin
                        // short line, mostly run to its end and a bit past
                        beat.end_x = COORD_BITS'(int'(x1) + int'($urandom_range(0, 48)) - 24);
                        beat.end_y = COORD_BITS'(int'(y1) + int'($urandom_range(0, 48)) - 24);
                        steps      = $urandom_range(0, 30);
                    end else begin
                        // wide line, cut off by the next start
                        beat.end_x = pick_coord();
                        beat.end_y = pick_coord();
                        steps      = $urandom_range(0, 12);
                    end
                    offer_beat(beat, 1'b0, NO_PIXEL);
                    repeat (steps) offer_beat(step_beat(), 1'b0, NO_PIXEL);
                end
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pixel_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
